FILE: hw/rtl/aplq_pkg.sv
// shared widths, sideband type and register addresses for the power-law quantizer
`timescale 1ns / 1ps
package aplq_pkg;

	localparam int SAMPLE_W = 32;
	localparam int GAIN_W   = 24;
	localparam int QUANT_W  = 16;
	localparam int OFFS_W   = 16;
	localparam int PROD_W   = 56;
	localparam int P_W      = 52;
	localparam int HALF_W   = P_W / 2;
	localparam int SQ_W     = 2 * P_W;
	localparam int CUBE_W   = 3 * P_W - 32;
	localparam int S_W      = CUBE_W / 2;
	localparam int T_W      = S_W / 2;
	localparam int REM1_W   = S_W + 2;
	localparam int REM2_W   = T_W + 2;
	localparam int R1_STEPS = S_W;
	localparam int R2_STEPS = T_W;
	localparam int ADDR_W   = 3;

	localparam logic [ADDR_W-1:0] ADDR_ROUND_OFFSET = 3'd0;
	localparam logic [OFFS_W-1:0] ROUND_OFFSET_RST  = 16'd26568;
	localparam logic [14:0]       QMAX              = 15'h7fff;

	typedef struct packed {
		logic neg;
		logic big;
		logic last;
	} side_t;

endpackage

FILE: hw/rtl/aplq_cube.sv
// pipelined cube of the 52-bit product, keeps bits above 2^32
`timescale 1ns / 1ps
module aplq_cube (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [aplq_pkg::P_W-1:0]    in_p,
	input  aplq_pkg::side_t             in_side,
	output logic                        out_vld,
	output logic [aplq_pkg::CUBE_W-1:0] out_c,
	output aplq_pkg::side_t             out_side
);
	localparam int H = aplq_pkg::HALF_W;
	localparam int P = aplq_pkg::P_W;

	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	aplq_pkg::side_t     side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [P-1:0]        p_s1, p_s2;
	logic [2*H-1:0]      ll_s1, lh_s1, hh_s1;
	logic [2*P-1:0]      sq_s2;
	logic [2*H-1:0]      plo_s3 [4];
	logic [2*H-1:0]      phi_s3 [4];
	logic [4*H+2*H-1:0]  lsum_s4, hsum_s4;
	logic [3*P-1:0]      cube_s5;

	logic [4*H+2*H-1:0]  lsum, hsum;

	always_comb begin
		lsum = '0;
		hsum = '0;
		for (int i = 0; i < 4; i++) begin
			lsum = lsum + ((6*H)'(plo_s3[i]) << (H * i));
			hsum = hsum + ((6*H)'(phi_s3[i]) << (H * i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_side;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			p_s1    <= in_p;
			ll_s1   <= in_p[H-1:0] * in_p[H-1:0];
			lh_s1   <= in_p[H-1:0] * in_p[P-1:H];
			hh_s1   <= in_p[P-1:H] * in_p[P-1:H];
			p_s2    <= p_s1;
			sq_s2   <= ((2*P)'(hh_s1) << (2*H)) + ((2*P)'(lh_s1) << (H+1))
				+ (2*P)'(ll_s1);
			for (int i = 0; i < 4; i++) begin
				plo_s3[i] <= sq_s2[H*i +: H] * p_s2[H-1:0];
				phi_s3[i] <= sq_s2[H*i +: H] * p_s2[P-1:H];
			end
			lsum_s4 <= lsum;
			hsum_s4 <= hsum;
			cube_s5 <= (3*P)'(lsum_s4) + ((3*P)'(hsum_s4) << H);
		end
	end

	assign out_vld  = vld_s5;
	assign out_side = side_s5;
	assign out_c    = cube_s5[3*P-1:32];

endmodule

FILE: hw/rtl/aplq_root.sv
// two chained digit-by-digit square roots, one digit per stage: floor of fourth root
`timescale 1ns / 1ps
module aplq_root (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [aplq_pkg::CUBE_W-1:0] in_c,
	input  aplq_pkg::side_t             in_side,
	output logic                        out_vld,
	output logic [aplq_pkg::T_W-1:0]    out_t,
	output aplq_pkg::side_t             out_side
);
	localparam int CW  = aplq_pkg::CUBE_W;
	localparam int SW  = aplq_pkg::S_W;
	localparam int TW  = aplq_pkg::T_W;
	localparam int RW1 = aplq_pkg::REM1_W;
	localparam int RW2 = aplq_pkg::REM2_W;
	localparam int N1  = aplq_pkg::R1_STEPS;
	localparam int N2  = aplq_pkg::R2_STEPS;

	logic [CW-1:0]   r1_rad_s  [N1];
	logic [RW1-1:0]  r1_rem_s  [N1];
	logic [SW-1:0]   r1_root_s [N1];
	logic            r1_vld_s  [N1];
	aplq_pkg::side_t r1_side_s [N1];

	logic [SW-1:0]   r2_rad_s  [N2];
	logic [RW2-1:0]  r2_rem_s  [N2];
	logic [TW-1:0]   r2_root_s [N2];
	logic            r2_vld_s  [N2];
	aplq_pkg::side_t r2_side_s [N2];

	genvar k;

	// first root: 124-bit radicand down to a 62-bit root
	for (k = 0; k < N1; k++) begin : g_r1
		logic [CW-1:0]   rad_i;
		logic [RW1-1:0]  rem_i;
		logic [SW-1:0]   root_i;
		logic            vld_i;
		aplq_pkg::side_t side_i;
		logic [RW1+1:0]  rem_sh, trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign rad_i  = in_c;
			assign rem_i  = '0;
			assign root_i = '0;
			assign vld_i  = in_vld;
			assign side_i = in_side;
		end else begin : g_next
			assign rad_i  = r1_rad_s[k-1];
			assign rem_i  = r1_rem_s[k-1];
			assign root_i = r1_root_s[k-1];
			assign vld_i  = r1_vld_s[k-1];
			assign side_i = r1_side_s[k-1];
		end

		assign rem_sh = {rem_i, rad_i[CW-1 -: 2]};
		assign trial  = {2'b00, root_i, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				r1_vld_s[k] <= 1'b0;
			end else if (en) begin
				r1_vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r1_side_s[k] <= side_i;
				r1_rad_s[k]  <= {rad_i[CW-3:0], 2'b00};
				r1_rem_s[k]  <= ge ? RW1'(rem_sh - trial) : RW1'(rem_sh);
				r1_root_s[k] <= {root_i[SW-2:0], ge};
			end
		end
	end

	// second root: 62-bit radicand down to a 31-bit root
	for (k = 0; k < N2; k++) begin : g_r2
		logic [SW-1:0]   rad_i;
		logic [RW2-1:0]  rem_i;
		logic [TW-1:0]   root_i;
		logic            vld_i;
		aplq_pkg::side_t side_i;
		logic [RW2+1:0]  rem_sh, trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign rad_i  = r1_root_s[N1-1];
			assign rem_i  = '0;
			assign root_i = '0;
			assign vld_i  = r1_vld_s[N1-1];
			assign side_i = r1_side_s[N1-1];
		end else begin : g_next
			assign rad_i  = r2_rad_s[k-1];
			assign rem_i  = r2_rem_s[k-1];
			assign root_i = r2_root_s[k-1];
			assign vld_i  = r2_vld_s[k-1];
			assign side_i = r2_side_s[k-1];
		end

		assign rem_sh = {rem_i, rad_i[SW-1 -: 2]};
		assign trial  = {2'b00, root_i, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				r2_vld_s[k] <= 1'b0;
			end else if (en) begin
				r2_vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r2_side_s[k] <= side_i;
				r2_rad_s[k]  <= {rad_i[SW-3:0], 2'b00};
				r2_rem_s[k]  <= ge ? RW2'(rem_sh - trial) : RW2'(rem_sh);
				r2_root_s[k] <= {root_i[TW-2:0], ge};
			end
		end
	end

	assign out_vld  = r2_vld_s[N2-1];
	assign out_t    = r2_root_s[N2-1];
	assign out_side = r2_side_s[N2-1];

endmodule

FILE: hw/rtl/aac_power_law_quantizer_core.sv
// top level: three-quarter-power quantizer pipeline with apb offset register
`timescale 1ns / 1ps
// Quantizes one signed Q16.16 coefficient per word with its band's Q8.16 gain:
// quantized = sign(sample) * min(floor((|sample|*gain)^0.75 + round_offset), 32767),
// overflow set when clipped, last_in carried to last_out. A new word is taken
// every cycle while the pipeline is not stalled; the pipeline registers the 32x24
// product, then the split cube multiply, then the two digit-per-stage square
// roots, then offset, saturation and sign. out_stall with out_valid high freezes
// the whole pipeline and is passed back as in_stall, so nothing is lost or repeated.
// round_offset sits at apb byte address 0 and resets to 26568 (about 0.4054).
module aac_power_law_quantizer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [aplq_pkg::ADDR_W-1:0]         paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [aplq_pkg::SAMPLE_W-1:0] sample,
	input  logic [aplq_pkg::GAIN_W-1:0]         gain,
	input  logic                                last_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [aplq_pkg::QUANT_W-1:0] quantized,
	output logic                                overflow,
	output logic                                last_out
);
	logic [aplq_pkg::OFFS_W-1:0] round_offset_q;
	logic                        en;

	logic [aplq_pkg::SAMPLE_W-1:0] mag;
	logic                          vld_s1;
	logic [aplq_pkg::PROD_W-1:0]   prod_s1;
	logic                          neg_s1, last_s1;
	aplq_pkg::side_t               side_s1;

	logic                          cube_vld;
	logic [aplq_pkg::CUBE_W-1:0]   cube_c;
	aplq_pkg::side_t               cube_side;

	logic                          root_vld;
	logic [aplq_pkg::T_W-1:0]      root_t;
	aplq_pkg::side_t               root_side;

	logic [31:0]                   sum;
	logic [15:0]                   qraw;
	logic                          sat;
	logic [14:0]                   qmag;

	assign pready = 1'b1;
	assign en     = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_offset_q <= aplq_pkg::ROUND_OFFSET_RST;
		end else if (psel && penable && pwrite && pready
			&& paddr == aplq_pkg::ADDR_ROUND_OFFSET) begin
			round_offset_q <= pwdata[aplq_pkg::OFFS_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr)
			aplq_pkg::ADDR_ROUND_OFFSET: prdata = {16'h0000, round_offset_q};
			default:                     prdata = '0;
		endcase
	end

	// most negative sample wraps to 2^31, which is its true magnitude
	assign mag = sample[aplq_pkg::SAMPLE_W-1] ? (~sample + 1'b1) : sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= mag * gain;
			neg_s1  <= sample[aplq_pkg::SAMPLE_W-1];
			last_s1 <= last_in;
		end
	end

	assign side_s1.neg  = neg_s1;
	assign side_s1.big  = |prod_s1[aplq_pkg::PROD_W-1:aplq_pkg::P_W];
	assign side_s1.last = last_s1;

	aplq_cube u_cube (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.in_p     (prod_s1[aplq_pkg::P_W-1:0]),
		.in_side  (side_s1),
		.out_vld  (cube_vld),
		.out_c    (cube_c),
		.out_side (cube_side)
	);

	aplq_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (cube_vld),
		.in_c     (cube_c),
		.in_side  (cube_side),
		.out_vld  (root_vld),
		.out_t    (root_t),
		.out_side (root_side)
	);

	assign sum  = {1'b0, root_t} + {16'h0000, round_offset_q};
	assign qraw = sum[31:16];
	assign sat  = root_side.big || qraw[15];
	assign qmag = sat ? aplq_pkg::QMAX : qraw[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= root_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quantized <= root_side.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
			overflow  <= sat;
			last_out  <= root_side.last;
		end
	end

	a_ovf_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> (quantized == 16'sd32767 || quantized == -16'sd32767))
		else $error("overflow without clipped magnitude");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quantized != 16'sh8000)
		else $error("quantized reached -32768");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(quantized) && $stable(overflow))
		else $error("stalled word changed");

endmodule
